// File: src/kmm_pkg.sv
package kmm_pkg;

  localparam int COLUMNS_DEFAULT = 8;
  localparam int ROWS_DEFAULT    = 4;

  localparam logic [7:0] NOTE_ON_STATUS    = 8'h90;
  localparam logic [6:0] VELOCITY_RESET    = 7'd127;
  localparam logic [6:0] LOWEST_NOTE_RESET = 7'd41;
  localparam logic [6:0] NOTE_MAX          = 7'd127;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_NOTE_VELOCITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWEST_NOTE   = 1'b1;

endpackage

// File: src/key_matrix_midi_note_events_unit.sv
// Flow: an accepted column is registered in the pending stage, then each note
// event in the output stage, one event per cycle while the output is not
// stalled; a column with no event (or out of range) leaves no pending events.
// Reset (rst_n low, synchronous): all keys released, velocity 127, lowest
// note 41, no event pending.
module key_matrix_midi_note_events_unit #(
  parameter int COLUMNS = kmm_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = kmm_pkg::ROWS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [kmm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kmm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_column_index,
  input  logic [3:0]                    in_row_levels,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_status_byte,
  output logic [6:0]                    out_note_number,
  output logic [6:0]                    out_velocity,
  output logic                          out_last_event
);

  localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [6:0] velocity_r;
  logic [6:0] lowest_note_r;

  logic [ROWS-1:0] flags_r [COLUMNS];

  logic            pend_valid_r;
  logic [ROWS-1:0] pend_prs_r;
  logic [ROWS-1:0] pend_rel_r;
  logic [CW-1:0]   pend_col_r;

  logic       out_valid_r;
  logic [6:0] out_note_r;
  logic [6:0] out_vel_r;
  logic       out_last_r;

  logic [4:0]      col5;
  logic            col_ok;
  logic [CW-1:0]   col_idx;
  logic [7:0]      lev8;
  logic [ROWS-1:0] lev;
  logic [ROWS-1:0] cur_flags;
  logic [ROWS-1:0] new_prs;
  logic [ROWS-1:0] new_rel;
  logic            in_xfer;

  logic            out_free;
  logic            fire;
  logic [RW-1:0]   sel_row;
  logic            sel_press;
  logic [ROWS-1:0] prs_nxt;
  logic [ROWS-1:0] rel_nxt;
  logic            sel_last;
  logic [CW-1:0]   col_m;
  logic [8:0]      note_sum;
  logic [6:0]      note_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      velocity_r    <= kmm_pkg::VELOCITY_RESET;
      lowest_note_r <= kmm_pkg::LOWEST_NOTE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        kmm_pkg::REG_NOTE_VELOCITY: velocity_r    <= cfg_wdata;
        kmm_pkg::REG_LOWEST_NOTE:   lowest_note_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign col5    = {2'b00, in_column_index};
  assign col_ok  = col5 < 5'(COLUMNS);
  assign col_idx = col5[CW-1:0];
  assign lev8    = {4'b0000, in_row_levels};
  assign lev     = lev8[ROWS-1:0];

  assign cur_flags = flags_r[col_idx];
  assign new_prs   = lev & ~cur_flags;
  assign new_rel   = ~lev & cur_flags;

  // event stage picks presses first, then releases, lowest row first
  always_comb begin
    sel_row   = '0;
    sel_press = 1'b0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (pend_rel_r[r]) begin
        sel_row   = RW'(r);
        sel_press = 1'b0;
      end
    end
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (pend_prs_r[r]) begin
        sel_row   = RW'(r);
        sel_press = 1'b1;
      end
    end
  end

  always_comb begin
    prs_nxt = pend_prs_r;
    rel_nxt = pend_rel_r;
    if (sel_press) begin
      prs_nxt = pend_prs_r & (pend_prs_r - 1'b1);
    end else begin
      rel_nxt = pend_rel_r & (pend_rel_r - 1'b1);
    end
  end

  assign sel_last = (prs_nxt == '0) && (rel_nxt == '0);

  assign col_m    = (pend_col_r == '0) ? CW'(COLUMNS - 1) : pend_col_r - CW'(1);
  assign note_sum = {2'b00, lowest_note_r} + 9'(COLUMNS) * 9'(sel_row) + 9'(col_m);
  assign note_sat = (note_sum > 9'(kmm_pkg::NOTE_MAX)) ? kmm_pkg::NOTE_MAX : note_sum[6:0];

  assign out_free = !out_valid_r || out_ready;
  assign fire     = pend_valid_r && out_free;
  assign in_ready = !pend_valid_r || (fire && sel_last);
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < COLUMNS; c++) begin
        flags_r[c] <= '0;
      end
    end else if (in_xfer && col_ok) begin
      flags_r[col_idx] <= lev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (in_xfer) begin
      pend_valid_r <= col_ok && ((new_prs | new_rel) != '0);
    end else if (fire && sel_last) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pend_prs_r <= new_prs;
      pend_rel_r <= new_rel;
      pend_col_r <= col_idx;
    end else if (fire) begin
      pend_prs_r <= prs_nxt;
      pend_rel_r <= rel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= pend_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_note_r <= note_sat;
      out_vel_r  <= sel_press ? velocity_r : 7'd0;
      out_last_r <= sel_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status_byte = kmm_pkg::NOTE_ON_STATUS;
  assign out_note_number = out_note_r;
  assign out_velocity    = out_vel_r;
  assign out_last_event  = out_last_r;

endmodule

// File: src/kmm_checker.sv
module kmm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_status_byte,
  input logic [6:0] out_note_number,
  input logic [6:0] out_velocity,
  input logic       out_last_event
);

  // no event survives reset
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status_byte == kmm_pkg::NOTE_ON_STATUS)
    else $error("status byte is not note-on");

  // events of one column follow back to back
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_event |=> out_valid)
    else $error("gap inside an event burst");

  // hold the input while a column still has events to send
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && !out_last_event |-> !in_ready)
    else $error("input taken mid burst");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_note_number)
      && $stable(out_velocity) && $stable(out_last_event))
    else $error("stalled result changed");

endmodule

bind key_matrix_midi_note_events_unit kmm_checker u_kmm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status_byte (out_status_byte),
  .out_note_number (out_note_number),
  .out_velocity    (out_velocity),
  .out_last_event  (out_last_event)
);

// File: tb/sv/note_event_checker.sv
`timescale 1ns / 100ps

module note_event_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [kmm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kmm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [2:0]                     in_column_index,
  input  logic [3:0]                     in_row_levels,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [7:0]                     out_status_byte,
  input  logic [6:0]                     out_note_number,
  input  logic [6:0]                     out_velocity,
  input  logic                           out_last_event,
  output int                             mismatch_count,
  output int                             events_pending
);

  localparam int NUM_COLS = kmm_pkg::COLUMNS_DEFAULT;
  localparam int NUM_ROWS = kmm_pkg::ROWS_DEFAULT;

  typedef struct packed {
    logic [7:0] status;
    logic [6:0] note;
    logic [6:0] velocity;
    logic       last;
  } note_event_t;

  note_event_t note_events_due[$];
  logic        key_down [NUM_COLS*NUM_ROWS];
  logic [6:0]  press_velocity;
  logic [6:0]  base_note;

  function automatic logic [6:0] note_of_key(int row, int col);
    int n;
    n = base_note + NUM_COLS * row + (col + NUM_COLS - 1) % NUM_COLS;
    if (n > kmm_pkg::NOTE_MAX) begin
      return kmm_pkg::NOTE_MAX;
    end
    return n[6:0];
  endfunction

  function automatic void scan_note_events(logic [2:0] col, logic [3:0] rows);
    logic [NUM_ROWS-1:0] pressed;
    logic [NUM_ROWS-1:0] released;
    int total;
    int k;
    int r;
    int key;
    pressed  = '0;
    released = '0;
    for (r = 0; r < NUM_ROWS; r++) begin
      key = col + NUM_COLS * r;
      pressed[r]  = rows[r] && !key_down[key];
      released[r] = !rows[r] && key_down[key];
    end
    total = $countones({pressed, released});
    k = 0;
    for (r = 0; r < NUM_ROWS; r++) begin
      if (pressed[r]) begin
        key_down[col + NUM_COLS * r] = 1'b1;
        k++;
        note_events_due.push_back('{kmm_pkg::NOTE_ON_STATUS, note_of_key(r, col),
                                    press_velocity, k == total});
      end
    end
    for (r = 0; r < NUM_ROWS; r++) begin
      if (released[r]) begin
        key_down[col + NUM_COLS * r] = 1'b0;
        k++;
        note_events_due.push_back('{kmm_pkg::NOTE_ON_STATUS, note_of_key(r, col),
                                    7'd0, k == total});
      end
    end
  endfunction

  always @(posedge clk) begin
    note_event_t seen;
    note_event_t due;
    if (!rst_n) begin
      press_velocity = kmm_pkg::VELOCITY_RESET;
      base_note      = kmm_pkg::LOWEST_NOTE_RESET;
      foreach (key_down[i]) key_down[i] = 1'b0;
      note_events_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          kmm_pkg::REG_NOTE_VELOCITY: press_velocity = cfg_wdata;
          kmm_pkg::REG_LOWEST_NOTE:   base_note = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        seen = '{out_status_byte, out_note_number, out_velocity, out_last_event};
        if (note_events_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected event: status %h note %0d velocity %0d last %0d",
                   $time, seen.status, seen.note, seen.velocity, seen.last);
        end else begin
          due = note_events_due.pop_front();
          if (seen !== due) begin
            mismatch_count++;
            $display("%0t: event mismatch: expected status %h note %0d velocity %0d last %0d",
                     $time, due.status, due.note, due.velocity, due.last);
            $display("%0t:                 actual   status %h note %0d velocity %0d last %0d",
                     $time, seen.status, seen.note, seen.velocity, seen.last);
          end
        end
      end
      if (in_valid && in_ready) begin
        scan_note_events(in_column_index, in_row_levels);
      end
    end
    events_pending = note_events_due.size();
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [kmm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [kmm_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           in_valid;
  logic                           in_ready;
  logic [2:0]                     in_column_index;
  logic [3:0]                     in_row_levels;
  logic                           out_valid;
  logic                           out_ready;
  logic [7:0]                     out_status_byte;
  logic [6:0]                     out_note_number;
  logic [6:0]                     out_velocity;
  logic                           out_last_event;

  int         mismatch_count;
  int         events_pending;
  int         phase = -1;
  bit         gaps_on = 1'b0;
  bit         stalls_on = 1'b0;
  bit         long_hold_done = 1'b0;
  logic [3:0] held_rows [8];

  key_matrix_midi_note_events_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_column_index (in_column_index),
    .in_row_levels   (in_row_levels),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status_byte (out_status_byte),
    .out_note_number (out_note_number),
    .out_velocity    (out_velocity),
    .out_last_event  (out_last_event)
  );

  note_event_checker u_note_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_column_index (in_column_index),
    .in_row_levels   (in_row_levels),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status_byte (out_status_byte),
    .out_note_number (out_note_number),
    .out_velocity    (out_velocity),
    .out_last_event  (out_last_event),
    .mismatch_count  (mismatch_count),
    .events_pending  (events_pending)
  );

  always #5 clk = ~clk;

  task automatic write_register(logic [kmm_pkg::CFG_IDX_W-1:0] idx, logic [6:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic apply_settings(logic [6:0] velocity, logic [6:0] lowest);
    write_register(kmm_pkg::REG_NOTE_VELOCITY, velocity);
    write_register(kmm_pkg::REG_LOWEST_NOTE, lowest);
  endtask

  task automatic scan_column(logic [2:0] col, logic [3:0] rows);
    @(negedge clk);
    in_valid        <= 1'b1;
    in_column_index <= col;
    in_row_levels   <= rows;
    held_rows[col]  = rows;
    do @(posedge clk); while (!in_ready);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 13)) @(negedge clk);
    end
  endtask

  // drop valid, drain all pending events, then cover items still in flight
  task automatic settle_block;
    @(negedge clk);
    in_valid <= 1'b0;
    while (events_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (phase == 1 && !long_hold_done) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (199) @(negedge clk);
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 13)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [2:0] col;
    logic [3:0] rows;
    logic [6:0] velocity;
    logic [6:0] lowest;
    int         pick;
    int         p;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_column_index = '0;
    in_row_levels   = '0;
    foreach (held_rows[i]) held_rows[i] = 4'h0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    scan_column(3'd0, 4'h0);
    scan_column(3'd0, 4'hF);
    scan_column(3'd0, 4'hF);
    scan_column(3'd7, 4'hF);
    scan_column(3'd0, 4'h0);
    scan_column(3'd3, 4'h5);
    scan_column(3'd3, 4'hA);
    scan_column(3'd7, 4'h0);
    scan_column(3'd5, 4'h1);
    scan_column(3'd5, 4'h8);
    settle_block();
    apply_settings(7'd0, 7'd0);
    scan_column(3'd1, 4'hF);
    scan_column(3'd1, 4'h0);
    settle_block();
    apply_settings(7'd127, 7'd127);
    scan_column(3'd0, 4'hF);
    scan_column(3'd6, 4'hF);
    scan_column(3'd0, 4'h0);
    scan_column(3'd6, 4'h0);
    settle_block();
    apply_settings(7'd1, 7'd96);
    scan_column(3'd0, 4'hF);
    scan_column(3'd0, 4'h0);
    scan_column(3'd3, 4'h0);
    scan_column(3'd5, 4'h0);
    settle_block();

    for (p = 0; p < 6; p++) begin
      phase = p;
      case (p)
        0: begin velocity = 7'd127; lowest = 7'd0; end
        1: begin velocity = 7'd0; lowest = 7'd96; end
        2: begin velocity = 7'($urandom_range(0, 127)); lowest = 7'd127; end
        3: begin velocity = 7'd64; lowest = 7'($urandom_range(0, 127)); end
        4: begin
          velocity = 7'($urandom_range(0, 127));
          lowest   = 7'($urandom_range(0, 127));
        end
        default: begin velocity = 7'd1; lowest = kmm_pkg::LOWEST_NOTE_RESET; end
      endcase
      gaps_on   = (p == 0 || p == 2 || p == 4);
      stalls_on = (p == 0 || p == 3 || p == 4);
      apply_settings(velocity, lowest);
      repeat (75) begin
        col  = 3'($urandom_range(0, 7));
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          rows = held_rows[col] ^ (4'h1 << $urandom_range(0, 3));
        end else if (pick < 7) begin
          rows = held_rows[col] ^ 4'($urandom_range(1, 15));
        end else if (pick < 9) begin
          rows = 4'($urandom_range(0, 15));
        end else begin
          rows = held_rows[col];
        end
        scan_column(col, rows);
      end
      settle_block();
    end

    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && events_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
